/* hdl/fmpc_pkg.sv */
// Shared types, codes and helper functions of the first-match packet rule classifier.
// No dependencies; the top and the cell files use it by scoped names.
`default_nettype none

package fmpc_pkg;

  localparam int RULE_SLOTS_DEF = 64;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [1:0] DIR_ANY    = 2'd2;
  localparam logic [1:0] ACK_ANY    = 2'd2;

  localparam logic [2:0] RSN_MATCH    = 3'd0;
  localparam logic [2:0] RSN_INACTIVE = 3'd1;
  localparam logic [2:0] RSN_XMAS     = 3'd2;
  localparam logic [2:0] RSN_NOMATCH  = 3'd3;
  localparam logic [2:0] RSN_UPDATE   = 3'd4;

  localparam logic [1:0] CONN_NONE    = 2'd0;
  localparam logic [1:0] CONN_SEEN    = 2'd1;
  localparam logic [1:0] CONN_SWAPPED = 2'd2;

  localparam logic [1:0] CFG_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_ANY_PROTO = 2'd1;
  localparam logic [1:0] CFG_OTH_PROTO = 2'd2;
  localparam logic [1:0] CFG_ANY_PORT  = 2'd3;

  typedef enum logic [1:0] {
    KIND_CLASSIFY = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_CLEAR    = 2'd2,
    KIND_NOP      = 2'd3
  } kind_t;

  typedef struct packed {
    logic [5:0]  rule_index;
    logic [1:0]  direction;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [5:0]  source_prefix;
    logic [31:0] destination_address;
    logic [5:0]  destination_prefix;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [4:0]  flag_bits;
  } pkt_t;

  typedef struct packed {
    logic        filter_enable;
    logic [7:0]  any_protocol_code;
    logic [7:0]  other_protocol_code;
    logic [15:0] any_port_code;
  } cfg_t;

  typedef struct packed {
    logic        active;
    logic        found;
    logic        verdict;
    logic [2:0]  reason;
    logic [5:0]  matched_rule;
    logic [1:0]  connection_add;
  } tok_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* hdl/first_match_packet_rule_classifier_top.sv */
// Top level of the first-match packet rule classifier: handshakes, config, cell chain.
// Depends on fmpc_pkg and fmpc_cell.
//
//  channel   dir  payload                                  handshake
//  in_*      in   tuser kind, tdata header/rule (136 b)    in_tvalid / in_tready
//  out_*     out  tdata verdict/reason/rule/conn (16 b)    out_tvalid / out_tready
//  cfg_*     in   index 2 b, data 16 b                     cfg_wr_en, no wait
//
// Write, clear and unused kinds are answered at transfer. A classify item walks
// the chain of RULE_SLOTS cells, one cell per cycle, through the inject register, each
// cell's token register and the result register; one item is in flight at a time.
// A disabled filter answers a classify item at transfer as well.
// Reset (synchronous, rst_n low) clears all rule valid bits and loads config defaults.
// A stalled result holds in the output register while the next item is taken.
`default_nettype none

module first_match_packet_rule_classifier_top #(
  parameter int RULE_SLOTS = fmpc_pkg::RULE_SLOTS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // [5:0] rule_index, [7:6] direction, [15:8] protocol, [47:16] source_address,
  // [53:48] source_prefix, [85:54] destination_address, [91:86] destination_prefix,
  // [107:92] source_port, [123:108] destination_port, [128:124] flag_bits, rest zero
  input  wire [135:0]  in_tdata,
  // [1:0] kind
  input  wire [1:0]    in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // [0] verdict, [3:1] reason, [9:4] matched_rule, [11:10] connection_add, rest zero
  output logic [15:0]  out_tdata,
  input  wire          cfg_wr_en,
  input  wire [1:0]    cfg_index,
  input  wire [15:0]   cfg_wdata
);

  fmpc_pkg::cfg_t cfg_r;
  fmpc_pkg::pkt_t in_pkt, pkt_r;
  fmpc_pkg::kind_t kind;
  fmpc_pkg::tok_t tok [RULE_SLOTS+1];
  fmpc_pkg::tok_t inj_r, res_r, res_nxt, out_r;
  logic busy_r, res_valid_r, out_valid_r;
  logic take, move, wr_en, clr;

  assign kind = fmpc_pkg::kind_t'(in_tuser);
  assign in_pkt.rule_index          = in_tdata[5:0];
  assign in_pkt.direction           = in_tdata[7:6];
  assign in_pkt.protocol            = in_tdata[15:8];
  assign in_pkt.source_address      = in_tdata[47:16];
  assign in_pkt.source_prefix       = in_tdata[53:48];
  assign in_pkt.destination_address = in_tdata[85:54];
  assign in_pkt.destination_prefix  = in_tdata[91:86];
  assign in_pkt.source_port         = in_tdata[107:92];
  assign in_pkt.destination_port    = in_tdata[123:108];
  assign in_pkt.flag_bits           = in_tdata[128:124];

  assign in_tready = !busy_r;
  assign take      = in_tvalid && in_tready;
  // drop writes aimed past the table; they still answer as an update
  assign wr_en = take && (kind == fmpc_pkg::KIND_WRITE) &&
                 (32'(in_pkt.rule_index) < RULE_SLOTS);
  assign clr   = take && (kind == fmpc_pkg::KIND_CLEAR);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_enable       <= 1'b1;
      cfg_r.any_protocol_code   <= 8'd143;
      cfg_r.other_protocol_code <= 8'd255;
      cfg_r.any_port_code       <= 16'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fmpc_pkg::CFG_ENABLE:    cfg_r.filter_enable       <= cfg_wdata[0];
        fmpc_pkg::CFG_ANY_PROTO: cfg_r.any_protocol_code   <= cfg_wdata[7:0];
        fmpc_pkg::CFG_OTH_PROTO: cfg_r.other_protocol_code <= cfg_wdata[7:0];
        fmpc_pkg::CFG_ANY_PORT:  cfg_r.any_port_code       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // hold the header under classification for the whole walk
  always_ff @(posedge clk) begin
    if (take) begin
      pkt_r <= in_pkt;
    end
  end

  // inject a token into the chain for an enabled classify
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inj_r <= '0;
    end else begin
      inj_r <= '0;
      if (take && (kind == fmpc_pkg::KIND_CLASSIFY) && cfg_r.filter_enable) begin
        inj_r.active <= 1'b1;
        inj_r.reason <= fmpc_pkg::RSN_NOMATCH;
      end
    end
  end

  assign tok[0] = inj_r;

  for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
    fmpc_cell #(.CELL_ID(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (wr_en),
      .clr     (clr),
      .wr_pkt  (in_pkt),
      .cmp_pkt (pkt_r),
      .cfg     (cfg_r),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  // result stage: short answers at transfer, chain answers at its end
  always_comb begin
    res_nxt = '0;
    if (take && (kind != fmpc_pkg::KIND_CLASSIFY)) begin
      res_nxt.active = 1'b1;
      res_nxt.reason = fmpc_pkg::RSN_UPDATE;
    end else if (take && !cfg_r.filter_enable) begin
      res_nxt.active = 1'b1;
      res_nxt.reason = fmpc_pkg::RSN_INACTIVE;
    end else begin
      res_nxt = tok[RULE_SLOTS];
    end
  end

  assign move = res_valid_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        busy_r <= 1'b1;
      end else if (move) begin
        busy_r <= 1'b0;
      end
      if (res_nxt.active) begin
        res_valid_r <= 1'b1;
      end else if (move) begin
        res_valid_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_nxt.active) begin
      res_r <= res_nxt;
    end
    if (move) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_r.connection_add, out_r.matched_rule,
                       out_r.reason, out_r.verdict};

endmodule

`default_nettype wire

/* hdl/fmpc_cell.sv */
// One rule slot of the classifier chain: rule storage, match logic, token stage.
// Depends on fmpc_pkg.
`default_nettype none

module fmpc_cell #(
  parameter int CELL_ID = 0
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              wr_en,
  input  wire              clr,
  input  fmpc_pkg::pkt_t   wr_pkt,
  input  fmpc_pkg::pkt_t   cmp_pkt,
  input  fmpc_pkg::cfg_t   cfg,
  input  fmpc_pkg::tok_t   tok_in,
  output fmpc_pkg::tok_t   tok_out
);

  logic        valid_r;
  logic [1:0]  dir_r;
  logic [7:0]  proto_r;
  logic [31:0] saddr_r, daddr_r;
  logic [5:0]  spre_r, dpre_r;
  logic [15:0] sport_r, dport_r;
  logic [1:0]  ack_r;
  logic        accept_r;

  fmpc_pkg::tok_t tok_r, tok_nxt;
  logic        hit;
  logic        is_tcp, has_ports, xmas;
  logic [31:0] sm, dm;
  logic        m_dir, m_proto, m_addr, m_port, m_ack;

  wire sel = wr_en && (32'(wr_pkt.rule_index) == CELL_ID);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clr) begin
      valid_r <= 1'b0;
    end else if (sel) begin
      valid_r <= 1'b1;
    end
  end

  // rule payload: no reset, read only once valid
  always_ff @(posedge clk) begin
    if (sel) begin
      dir_r    <= wr_pkt.direction;
      proto_r  <= wr_pkt.protocol;
      saddr_r  <= wr_pkt.source_address;
      daddr_r  <= wr_pkt.destination_address;
      spre_r   <= wr_pkt.source_prefix;
      dpre_r   <= wr_pkt.destination_prefix;
      sport_r  <= wr_pkt.source_port;
      dport_r  <= wr_pkt.destination_port;
      ack_r    <= wr_pkt.flag_bits[1:0];
      accept_r <= wr_pkt.flag_bits[2];
    end
  end

  always_comb begin
    is_tcp    = (cmp_pkt.protocol == fmpc_pkg::PROTO_TCP);
    has_ports = is_tcp || (cmp_pkt.protocol == fmpc_pkg::PROTO_UDP);
    xmas      = (cmp_pkt.flag_bits[3:1] == 3'b111);
    sm        = fmpc_pkg::prefix_mask(spre_r);
    dm        = fmpc_pkg::prefix_mask(dpre_r);
    m_dir     = (dir_r == fmpc_pkg::DIR_ANY) || (dir_r == cmp_pkt.direction);
    m_proto   = (proto_r == cfg.any_protocol_code) || (proto_r == cmp_pkt.protocol) ||
                ((proto_r == cfg.other_protocol_code) &&
                 (cmp_pkt.protocol != fmpc_pkg::PROTO_ICMP) &&
                 (cmp_pkt.protocol != fmpc_pkg::PROTO_TCP) &&
                 (cmp_pkt.protocol != fmpc_pkg::PROTO_UDP));
    m_addr    = ((saddr_r & sm) == (cmp_pkt.source_address & sm)) &&
                ((daddr_r & dm) == (cmp_pkt.destination_address & dm));
    m_port    = !has_ports ||
                (((sport_r == cmp_pkt.source_port) || (sport_r == cfg.any_port_code)) &&
                 ((dport_r == cmp_pkt.destination_port) || (dport_r == cfg.any_port_code)));
    m_ack     = !is_tcp || (ack_r == fmpc_pkg::ACK_ANY) ||
                (ack_r == {1'b0, cmp_pkt.flag_bits[0]});
    hit       = tok_in.active && !tok_in.found && valid_r &&
                m_dir && m_proto && m_addr && m_port && m_ack;

    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.found        = 1'b1;
      tok_nxt.matched_rule = 6'(CELL_ID);
      if (is_tcp && xmas) begin
        tok_nxt.verdict        = 1'b0;
        tok_nxt.reason         = fmpc_pkg::RSN_XMAS;
        tok_nxt.connection_add = fmpc_pkg::CONN_NONE;
      end else begin
        tok_nxt.verdict        = accept_r;
        tok_nxt.reason         = fmpc_pkg::RSN_MATCH;
        tok_nxt.connection_add = (is_tcp && accept_r) ?
                                 (cmp_pkt.flag_bits[4] ? fmpc_pkg::CONN_SWAPPED
                                                       : fmpc_pkg::CONN_SEEN)
                                 : fmpc_pkg::CONN_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

/* hdl/fmpc_checker.sv */
// Port-level checker for the first-match packet rule classifier, bound to the top.
// Depends on first_match_packet_rule_classifier_top ports only.
`default_nettype none

module fmpc_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [15:0]  out_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:1] <= 3'd4))
    else $error("reason out of range");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> (out_tdata[3:1] == 3'd0))
    else $error("accept without a matching rule");

  a_conn: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[11:10] != 2'd0) |-> out_tdata[0])
    else $error("connection add on a drop");

endmodule

bind first_match_packet_rule_classifier_top fmpc_checker u_fmpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
